// ===== hw/rtl/led_strip_frame_buffer_top_defines.svh =====
// ----------------------------------------------------------------------------
// LED strip frame buffer assertion macros
// Assertion helpers for the frame buffer RTL, used by lsfb_back.
// ----------------------------------------------------------------------------
`ifndef LED_STRIP_FRAME_BUFFER_TOP_DEFINES_SVH
`define LED_STRIP_FRAME_BUFFER_TOP_DEFINES_SVH

`ifndef SYNTH

// Property that must hold at every clock edge outside reset.
`define LSFB_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define LSFB_ASSERT_NEVER(name, clk, rst_n, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define LSFB_ASSERT(name, clk, rst_n, prop, msg)
`define LSFB_ASSERT_NEVER(name, clk, rst_n, expr, msg)

`endif

`endif

// ===== hw/rtl/lsfb_pkg.sv =====
// ----------------------------------------------------------------------------
// LED strip frame buffer package
// Widths, codes, constants and the command and result records.
// ----------------------------------------------------------------------------
package lsfb_pkg;

    localparam int MODE_W        = 3;
    localparam int BYTE_W        = 8;
    localparam int LEN_W         = 6;
    localparam int WORD_W        = 32;
    localparam int STRIP_MAX_DEF = 32;
    localparam int Q_DEPTH       = 2;

    localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(32);
    localparam logic [WORD_W-1:0] WORD_START = 32'h0000_0000;
    localparam logic [WORD_W-1:0] WORD_END   = 32'hFFFF_FFFF;
    localparam logic [BYTE_W-1:0] BRI_PAD    = 8'hE0;

    // Request modes as they arrive on the input channel.
    typedef enum logic [MODE_W-1:0] {
        MODE_SET   = 3'd0,
        MODE_FILL  = 3'd1,
        MODE_REMAP = 3'd2,
        MODE_SWAP  = 3'd3,
        MODE_VIRT  = 3'd4,
        MODE_SEND  = 3'd5
    } t_mode;

    // Classified operation handed to the execution side.
    typedef enum logic [2:0] {
        OP_SET,
        OP_FILL,
        OP_REMAP,
        OP_SWAP,
        OP_VIRT,
        OP_NONE
    } t_op;

    typedef struct packed {
        t_op               op;
        logic              err;
        logic              send;
        logic              wc;
        logic              wb;
        logic [BYTE_W-1:0] idx;
        logic [BYTE_W-1:0] tgt;
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] bright;
    } t_cmd;

    typedef struct packed {
        logic              kind;
        logic [WORD_W-1:0] word;
        logic              last;
        logic              err;
    } t_res;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SET,
        ST_FILL,
        ST_REMAP,
        ST_SWAP,
        ST_VIRT,
        ST_STATUS,
        ST_FR_START,
        ST_FR_BODY,
        ST_FR_END
    } t_state;

endpackage

// ===== hw/rtl/lsfb_if.sv =====
// ----------------------------------------------------------------------------
// LED strip frame buffer channels
// Valid/ready channels for requests in and results out.
// ----------------------------------------------------------------------------
interface lsfb_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [7:0] index;
    logic [7:0] target;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] bright;
    logic       write_colour;
    logic       write_brightness;
    logic       send;

    modport source (
        output valid, mode, index, target, red, green, blue, bright,
               write_colour, write_brightness, send,
        input  ready
    );
    modport sink (
        input  valid, mode, index, target, red, green, blue, bright,
               write_colour, write_brightness, send,
        output ready
    );
endinterface

interface lsfb_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] frame_word;
    logic        last;
    logic        error;

    modport source (output valid, kind, frame_word, last, error, input ready);
    modport sink (input valid, kind, frame_word, last, error, output ready);
endinterface

// ===== hw/rtl/lsfb_front.sv =====
// ----------------------------------------------------------------------------
// LED strip frame buffer front end
// Accepts requests, checks their indexes against the strip length and
// turns them into operation records for the queue.
// ----------------------------------------------------------------------------
module lsfb_front (
    lsfb_cmd_if.sink                   i_cmd,
    input  logic [lsfb_pkg::LEN_W-1:0] i_len,
    input  logic                       i_full,
    output logic                       o_push,
    output lsfb_pkg::t_cmd             o_cmd
);
    import lsfb_pkg::*;

    logic w_idx_ok;
    logic w_tgt_ok;

    // A request is taken whenever the queue has room.
    assign i_cmd.ready = !i_full;
    assign o_push      = i_cmd.valid && !i_full;

    assign w_idx_ok = i_cmd.index  < BYTE_W'(i_len);
    assign w_tgt_ok = i_cmd.target < BYTE_W'(i_len);

    // Decode the mode and decide whether the request is out of range.
    always_comb begin
        o_cmd        = '0;
        o_cmd.send   = i_cmd.send;
        o_cmd.wc     = i_cmd.write_colour;
        o_cmd.wb     = i_cmd.write_brightness;
        o_cmd.idx    = i_cmd.index;
        o_cmd.tgt    = i_cmd.target;
        o_cmd.red    = i_cmd.red;
        o_cmd.green  = i_cmd.green;
        o_cmd.blue   = i_cmd.blue;
        o_cmd.bright = i_cmd.bright;
        unique case (t_mode'(i_cmd.mode))
            MODE_SET: begin
                o_cmd.op  = OP_SET;
                o_cmd.err = !w_idx_ok;
            end
            MODE_FILL: begin
                o_cmd.op  = OP_FILL;
                o_cmd.err = 1'b0;
            end
            MODE_REMAP: begin
                o_cmd.op  = OP_REMAP;
                o_cmd.err = !w_idx_ok || !w_tgt_ok;
            end
            MODE_SWAP: begin
                o_cmd.op  = OP_SWAP;
                o_cmd.err = !w_idx_ok || !w_tgt_ok;
            end
            MODE_VIRT: begin
                o_cmd.op  = OP_VIRT;
                o_cmd.err = !w_idx_ok;
            end
            default: begin
                // Send-only and the unused codes change nothing.
                o_cmd.op  = OP_NONE;
                o_cmd.err = 1'b0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/lsfb_queue.sv =====
// ----------------------------------------------------------------------------
// LED strip frame buffer operation queue
// Short FIFO between the front end and the execution side.
// ----------------------------------------------------------------------------
module lsfb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lsfb_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output lsfb_pkg::t_cmd o_cmd
);
    import lsfb_pkg::*;

    localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    t_cmd           r_q [Q_DEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QAW:0]   r_count;
    logic [QAW-1:0] n_wr_ptr;
    logic [QAW-1:0] n_rd_ptr;
    logic [QAW:0]   n_count;
    logic           w_push;
    logic           w_pop;

    assign o_full  = r_count == (QAW+1)'(Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_q[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == QAW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + QAW'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == QAW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + QAW'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + (QAW+1)'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - (QAW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== hw/rtl/lsfb_back.sv =====
// ----------------------------------------------------------------------------
// LED strip frame buffer execution side
// Holds the pixel, map and virtual-flag stores, carries out queued
// operations and streams status and frame words into the output register.
// ----------------------------------------------------------------------------
`include "led_strip_frame_buffer_top_defines.svh"

module lsfb_back #(
    parameter int STRIP_MAX = lsfb_pkg::STRIP_MAX_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [lsfb_pkg::LEN_W-1:0] i_len,
    input  logic                       i_q_valid,
    input  lsfb_pkg::t_cmd             i_q_cmd,
    output logic                       o_q_pop,
    lsfb_res_if.source                 o_res
);
    import lsfb_pkg::*;

    localparam int IW  = (STRIP_MAX > 1) ? $clog2(STRIP_MAX) : 1;
    localparam int CW  = 3 * BYTE_W;

    // Stores: colour {blue, green, red}, brightness and the remap table.
    logic [CW-1:0]     m_col [STRIP_MAX];
    logic [BYTE_W-1:0] m_bri [STRIP_MAX];
    logic [IW-1:0]     m_map [STRIP_MAX];

    logic [STRIP_MAX-1:0] r_col_vld;
    logic [STRIP_MAX-1:0] r_bri_vld;
    logic [STRIP_MAX-1:0] r_map_vld;
    logic [STRIP_MAX-1:0] r_virt;

    logic [CW-1:0]     r_col_q;
    logic [BYTE_W-1:0] r_bri_q;
    logic              r_colv_q;
    logic              r_briv_q;
    logic [IW-1:0]     r_map_q;
    logic              r_mapv_q;

    t_state        r_state;
    t_state        n_state;
    t_cmd          r_cmd;
    t_cmd          n_cmd;
    logic [IW-1:0] r_i;
    logic [IW-1:0] n_i;
    logic          r_out_valid;
    logic          n_out_valid;
    t_res          r_out;
    t_res          n_out;

    logic          w_slot;
    logic          w_emit;
    t_res          w_emit_res;
    logic          w_col_we;
    logic          w_bri_we;
    logic [IW-1:0] w_wr_addr;
    logic          w_pix_rd_en;
    logic [IW-1:0] w_pix_rd_addr;
    logic          w_map_rd_en;
    logic          w_map_we;
    logic [IW-1:0] w_map_wa;
    logic [IW-1:0] w_map_wd;
    logic          w_virt_set;
    logic [IW-1:0] w_idx;
    logic [IW-1:0] w_tgt;
    logic          w_last_i;
    t_state        w_done_state;
    logic [CW-1:0]     w_col_val;
    logic [BYTE_W-1:0] w_bri_val;

    assign w_idx        = r_cmd.idx[IW-1:0];
    assign w_tgt        = r_cmd.tgt[IW-1:0];
    assign w_last_i     = (LEN_W'(r_i) + LEN_W'(1)) == i_len;
    assign w_done_state = r_cmd.send ? ST_FR_START : ST_STATUS;
    assign w_slot       = !r_out_valid || o_res.ready;
    assign w_col_val    = r_colv_q ? r_col_q : '0;
    assign w_bri_val    = r_briv_q ? r_bri_q : '0;

    // Operation sequencer: next state, store strobes and result requests.
    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_i           = r_i;
        o_q_pop       = 1'b0;
        w_col_we      = 1'b0;
        w_bri_we      = 1'b0;
        w_wr_addr     = r_i;
        w_pix_rd_en   = 1'b0;
        w_pix_rd_addr = r_i;
        w_map_rd_en   = 1'b0;
        w_map_we      = 1'b0;
        w_map_wa      = w_idx;
        w_map_wd      = w_tgt;
        w_virt_set    = 1'b0;
        w_emit        = 1'b0;
        w_emit_res    = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_i     = '0;
                    if (i_q_cmd.err) begin
                        n_state = ST_STATUS;
                    end else begin
                        unique case (i_q_cmd.op)
                            OP_SET:   n_state = ST_LOOKUP;
                            OP_FILL:  n_state = ST_FILL;
                            OP_REMAP: n_state = ST_REMAP;
                            OP_SWAP:  n_state = ST_REMAP;
                            OP_VIRT:  n_state = ST_VIRT;
                            OP_NONE:  n_state = i_q_cmd.send ? ST_FR_START : ST_STATUS;
                            default:  n_state = ST_STATUS;
                        endcase
                    end
                end
            end
            ST_LOOKUP: begin
                // Fetch the physical position of the logical LED.
                w_map_rd_en = 1'b1;
                n_state     = ST_SET;
            end
            ST_SET: begin
                w_wr_addr = r_mapv_q ? r_map_q : w_idx;
                w_col_we  = r_cmd.wc;
                w_bri_we  = r_cmd.wb;
                n_state   = w_done_state;
            end
            ST_FILL: begin
                if (i_len == '0) begin
                    n_state = w_done_state;
                end else begin
                    w_col_we = r_cmd.wc;
                    w_bri_we = r_cmd.wb;
                    if (w_last_i) begin
                        n_state = w_done_state;
                    end else begin
                        n_i = r_i + IW'(1);
                    end
                end
            end
            ST_REMAP: begin
                w_map_we = 1'b1;
                n_state  = (r_cmd.op == OP_SWAP) ? ST_SWAP : w_done_state;
            end
            ST_SWAP: begin
                // Second half of a swap: the target entry points back.
                w_map_we = 1'b1;
                w_map_wa = w_tgt;
                w_map_wd = w_idx;
                n_state  = w_done_state;
            end
            ST_VIRT: begin
                w_virt_set = 1'b1;
                n_state    = w_done_state;
            end
            ST_STATUS: begin
                if (w_slot) begin
                    w_emit          = 1'b1;
                    w_emit_res.kind = 1'b0;
                    w_emit_res.word = '0;
                    w_emit_res.last = 1'b1;
                    w_emit_res.err  = r_cmd.err;
                    n_state         = ST_IDLE;
                end
            end
            ST_FR_START: begin
                if (w_slot) begin
                    w_emit          = 1'b1;
                    w_emit_res.kind = 1'b1;
                    w_emit_res.word = WORD_START;
                    n_i             = '0;
                    w_pix_rd_en     = 1'b1;
                    w_pix_rd_addr   = '0;
                    n_state         = (i_len == '0) ? ST_FR_END : ST_FR_BODY;
                end
            end
            ST_FR_BODY: begin
                // The read registers hold LED r_i; virtual LEDs are skipped.
                if (r_virt[r_i] || w_slot) begin
                    if (!r_virt[r_i]) begin
                        w_emit          = 1'b1;
                        w_emit_res.kind = 1'b1;
                        w_emit_res.word = {w_bri_val | BRI_PAD, w_col_val};
                    end
                    if (w_last_i) begin
                        n_state = ST_FR_END;
                    end else begin
                        n_i           = r_i + IW'(1);
                        w_pix_rd_en   = 1'b1;
                        w_pix_rd_addr = r_i + IW'(1);
                    end
                end
            end
            ST_FR_END: begin
                if (w_slot) begin
                    w_emit          = 1'b1;
                    w_emit_res.kind = 1'b1;
                    w_emit_res.word = WORD_END;
                    w_emit_res.last = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output register: loads a new result or drains when taken.
    always_comb begin
        n_out_valid = r_out_valid && !o_res.ready;
        n_out       = r_out;
        if (w_emit) begin
            n_out_valid = 1'b1;
            n_out       = w_emit_res;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.kind       = r_out.kind;
    assign o_res.frame_word = r_out.word;
    assign o_res.last       = r_out.last;
    assign o_res.error      = r_out.err;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and sequencing registers.
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_i   <= n_i;
        r_out <= n_out;
    end

    // Per-entry valid bits and virtual flags; an unwritten entry reads
    // as its reset value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_vld <= '0;
            r_bri_vld <= '0;
            r_map_vld <= '0;
            r_virt    <= '0;
        end else begin
            if (w_col_we) begin
                r_col_vld[w_wr_addr] <= 1'b1;
            end
            if (w_bri_we) begin
                r_bri_vld[w_wr_addr] <= 1'b1;
            end
            if (w_map_we) begin
                r_map_vld[w_map_wa] <= 1'b1;
            end
            if (w_virt_set) begin
                r_virt[w_idx] <= 1'b1;
            end
        end
    end

    // Pixel memories: one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_col_we) begin
            m_col[w_wr_addr] <= {r_cmd.blue, r_cmd.green, r_cmd.red};
        end
        if (w_bri_we) begin
            m_bri[w_wr_addr] <= r_cmd.bright;
        end
        if (w_pix_rd_en) begin
            r_col_q  <= m_col[w_pix_rd_addr];
            r_bri_q  <= m_bri[w_pix_rd_addr];
            r_colv_q <= r_col_vld[w_pix_rd_addr];
            r_briv_q <= r_bri_vld[w_pix_rd_addr];
        end
    end

    // Remap memory: one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_map_we) begin
            m_map[w_map_wa] <= w_map_wd;
        end
        if (w_map_rd_en) begin
            r_map_q  <= m_map[w_idx];
            r_mapv_q <= r_map_vld[w_idx];
        end
    end

    `LSFB_ASSERT(a_no_virtual_word, i_clk, i_rst_n, (r_state == ST_FR_BODY && w_emit) |-> !r_virt[r_i], "frame word emitted for a virtual LED")
    `LSFB_ASSERT_NEVER(a_error_changes_nothing, i_clk, i_rst_n, r_state != ST_IDLE && r_cmd.err && (w_col_we || w_bri_we || w_map_we || w_virt_set), "failed request wrote a store")
    `LSFB_ASSERT(a_emit_has_slot, i_clk, i_rst_n, w_emit |-> (!r_out_valid || o_res.ready), "result overwrote a pending result")
    `LSFB_ASSERT(a_scan_in_range, i_clk, i_rst_n, (r_state == ST_FR_BODY || r_state == ST_FILL) && i_len != '0 |-> (LEN_W'(r_i) < i_len), "LED counter past strip length")

endmodule

// ===== hw/rtl/led_strip_frame_buffer_top.sv =====
// ----------------------------------------------------------------------------
// LED strip frame buffer
// Pixel store and frame generator for an APA102-style LED strip.
// ----------------------------------------------------------------------------
// A request is classified on arrival and placed in a two-entry queue, so up
// to two further requests are taken while an earlier one is still being
// carried out. The sequencer takes a queued request from the queue head while
// it is idle. A rejected request goes straight to its status word. Remap and
// mark-virtual write their entry and then give status. A swap writes both map
// entries in turn, and a single-LED set reads the remap table before it
// writes. The pixel memory has a single write port, so a fill visits one LED
// per cycle; at zero length it writes nothing. With send set, a request that
// is not rejected gives the frame in place of its status word. The frame is
// the start word, then one word per LED in use, then the end word. A virtual
// LED is stepped over without giving a word, and a stalled sink holds the
// sequencer. Each result is registered in the output register before it
// leaves. The stores come out of reset ready to use; no clearing pass is
// needed. strip_length must only be written while the block is idle.
// ----------------------------------------------------------------------------
module led_strip_frame_buffer_top #(
    parameter int STRIP_MAX = lsfb_pkg::STRIP_MAX_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [lsfb_pkg::LEN_W-1:0] i_cfg_wdata,
    lsfb_cmd_if.sink                   i_cmd,
    lsfb_res_if.source                 o_res
);
    import lsfb_pkg::*;

    logic [LEN_W-1:0] r_strip_length;
    logic [LEN_W-1:0] w_len;
    logic             w_push;
    t_cmd             w_push_cmd;
    logic             w_full;
    logic             w_q_valid;
    t_cmd             w_q_cmd;
    logic             w_q_pop;

    // Length register and its clamp to the store depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strip_length <= LEN_RESET;
        end else if (i_cfg_we) begin
            r_strip_length <= i_cfg_wdata;
        end
    end

    assign w_len = (r_strip_length > LEN_W'(STRIP_MAX)) ? LEN_W'(STRIP_MAX) : r_strip_length;

    lsfb_front u_front (
        .i_cmd  (i_cmd),
        .i_len  (w_len),
        .i_full (w_full),
        .o_push (w_push),
        .o_cmd  (w_push_cmd)
    );

    lsfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_q_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    lsfb_back #(
        .STRIP_MAX (STRIP_MAX)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_len     (w_len),
        .i_q_valid (w_q_valid),
        .i_q_cmd   (w_q_cmd),
        .o_q_pop   (w_q_pop),
        .o_res     (o_res)
    );

endmodule

// ===== test/tb_led_strip_frame_buffer_top.sv =====
// ----------------------------------------------------------------------------
// LED strip frame buffer testbench
// Drives set, fill, remap, swap, mark-virtual and send requests into the
// frame buffer and checks every status and frame word it returns. The
// expected words come from a local model of the pixel store, the remap table
// and the virtual flags. Strip length changes between phases while the block
// is idle, and both channels stall at random.
// ----------------------------------------------------------------------------
module tb_led_strip_frame_buffer_top;
    import lsfb_pkg::*;

    localparam int STRIP_MAX   = STRIP_MAX_DEF;
    localparam int STALL_LIMIT = 5000;
    localparam int END_CYCLES  = 40;
    localparam int CHUNKS      = 9;
    localparam int CHUNK_ITEMS = 38;

    // Modes six and seven have no name in the package; they behave as send only.
    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [7:0]        index;
        logic [7:0]        target;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic [7:0]        bright;
        logic              write_colour;
        logic              write_brightness;
        logic              send;
    } t_strip_req;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [LEN_W-1:0] cfg_wdata;

    lsfb_cmd_if cmd_if ();
    lsfb_res_if res_if ();

    led_strip_frame_buffer_top #(
        .STRIP_MAX (STRIP_MAX)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_cmd       (cmd_if),
        .o_res       (res_if)
    );

    // Request stream, expected output words and stall settings.
    t_strip_req   request_queue[$];
    t_strip_req   in_flight;
    t_res         results_due[$];
    int           src_idle_pct;
    int           snk_idle_pct;
    int           error_count;
    int           stall_cycles;

    // Local copy of the pixel store, remap table, virtual flags and length.
    logic [7:0]       red_mem    [STRIP_MAX];
    logic [7:0]       green_mem  [STRIP_MAX];
    logic [7:0]       blue_mem   [STRIP_MAX];
    logic [7:0]       bright_mem [STRIP_MAX];
    logic [4:0]       remap_mem  [STRIP_MAX];
    logic             virt_mem   [STRIP_MAX];
    logic [LEN_W-1:0] strip_len;

    // Clock generation.
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int effective_length();
        return (strip_len > STRIP_MAX) ? STRIP_MAX : int'(strip_len);
    endfunction

    function automatic t_res make_result(logic kind, logic [31:0] word, logic last,
                                         logic err);
        t_res r;
        r.kind = kind;
        r.word = word;
        r.last = last;
        r.err  = err;
        return r;
    endfunction

    task automatic store_pixel(int p, t_strip_req r);
        if (r.write_colour) begin
            red_mem[p]   = r.red;
            green_mem[p] = r.green;
            blue_mem[p]  = r.blue;
        end
        if (r.write_brightness) begin
            bright_mem[p] = r.bright;
        end
    endtask

    // Apply one accepted request to the local store and queue the words it produces.
    task automatic apply_strip_request(t_strip_req r);
        int len;
        bit bad;
        len = effective_length();
        bad = 1'b0;
        case (r.mode)
            MODE_SET: begin
                if (r.index >= len) bad = 1'b1;
                else store_pixel(remap_mem[r.index], r);
            end
            MODE_FILL: begin
                for (int i = 0; i < len; i++) store_pixel(i, r);
            end
            MODE_REMAP: begin
                if (r.index >= len || r.target >= len) bad = 1'b1;
                else remap_mem[r.index] = r.target[4:0];
            end
            MODE_SWAP: begin
                // Entries are cross-linked, not exchanged.
                if (r.index >= len || r.target >= len) begin
                    bad = 1'b1;
                end else begin
                    remap_mem[r.index]  = r.target[4:0];
                    remap_mem[r.target] = r.index[4:0];
                end
            end
            MODE_VIRT: begin
                if (r.index >= len) bad = 1'b1;
                else virt_mem[r.index] = 1'b1;
            end
            default: ;
        endcase

        if (bad) begin
            results_due.push_back(make_result(1'b0, 32'h0, 1'b1, 1'b1));
        end else if (!r.send) begin
            results_due.push_back(make_result(1'b0, 32'h0, 1'b1, 1'b0));
        end else begin
            // Start word, one word per physical LED in use, end word.
            results_due.push_back(make_result(1'b1, WORD_START, 1'b0, 1'b0));
            for (int i = 0; i < len; i++) begin
                if (!virt_mem[i]) begin
                    results_due.push_back(make_result(1'b1,
                        {bright_mem[i] | BRI_PAD, blue_mem[i], green_mem[i], red_mem[i]},
                        1'b0, 1'b0));
                end
            end
            results_due.push_back(make_result(1'b1, WORD_END, 1'b1, 1'b0));
        end
    endtask

    task automatic queue_request(logic [MODE_W-1:0] mode, logic [7:0] index,
                                 logic [7:0] target, logic [7:0] red, logic [7:0] green,
                                 logic [7:0] blue, logic [7:0] bright, logic wc, logic wb,
                                 logic snd);
        t_strip_req r;
        r.mode             = mode;
        r.index            = index;
        r.target           = target;
        r.red              = red;
        r.green            = green;
        r.blue             = blue;
        r.bright           = bright;
        r.write_colour     = wc;
        r.write_brightness = wb;
        r.send             = snd;
        request_queue.push_back(r);
    endtask

    // Pick an LED index: mostly in range, sometimes anywhere in the byte.
    function automatic logic [7:0] random_index(int len);
        if (len > 0 && $urandom_range(99) < 85) return 8'($urandom_range(len - 1));
        return 8'($urandom_range(255));
    endfunction

    task automatic queue_random_request();
        int               len;
        int               pick;
        logic [MODE_W-1:0] mode;
        logic             snd;
        len  = effective_length();
        pick = $urandom_range(99);
        if (pick < 30)      mode = MODE_SET;
        else if (pick < 38) mode = MODE_FILL;
        else if (pick < 52) mode = MODE_REMAP;
        else if (pick < 64) mode = MODE_SWAP;
        else if (pick < 66) mode = MODE_VIRT;
        else if (pick < 90) mode = MODE_SEND;
        else if (pick < 95) mode = MODE_SPARE_6;
        else                mode = MODE_SPARE_7;
        if (mode == MODE_SEND) snd = ($urandom_range(99) < 80);
        else                   snd = ($urandom_range(99) < 45);
        queue_request(mode, random_index(len), random_index(len), 8'($urandom),
                      8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                      1'($urandom), snd);
    endtask

    // Wait until every request is taken and every expected word has arrived.
    task automatic wait_strip_idle();
        do @(negedge clk);
        while (request_queue.size() != 0 || cmd_if.valid || results_due.size() != 0);
    endtask

    task automatic write_strip_length(logic [LEN_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        strip_len  = value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Request driver: takes items from the queue and holds them until accepted.
    always @(posedge clk) begin
        if (!rst_n) begin
            cmd_if.valid <= 1'b0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                apply_strip_request(in_flight);
            end
            if (!cmd_if.valid || cmd_if.ready) begin
                if (request_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    in_flight                = request_queue.pop_front();
                    cmd_if.valid            <= 1'b1;
                    cmd_if.mode             <= in_flight.mode;
                    cmd_if.index            <= in_flight.index;
                    cmd_if.target           <= in_flight.target;
                    cmd_if.red              <= in_flight.red;
                    cmd_if.green            <= in_flight.green;
                    cmd_if.blue             <= in_flight.blue;
                    cmd_if.bright           <= in_flight.bright;
                    cmd_if.write_colour     <= in_flight.write_colour;
                    cmd_if.write_brightness <= in_flight.write_brightness;
                    cmd_if.send             <= in_flight.send;
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each accepted word with the oldest expectation.
    always @(posedge clk) begin
        t_res want;
        if (!rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (results_due.size() == 0) begin
                    $error("unexpected result: kind %0d frame_word %08h last %0d error %0d",
                           res_if.kind, res_if.frame_word, res_if.last, res_if.error);
                    error_count++;
                end else begin
                    want = results_due.pop_front();
                    if (res_if.kind !== want.kind) begin
                        $error("kind mismatch: expected %0d, actual %0d",
                               want.kind, res_if.kind);
                        error_count++;
                    end
                    if (res_if.frame_word !== want.word) begin
                        $error("frame_word mismatch: expected %08h, actual %08h",
                               want.word, res_if.frame_word);
                        error_count++;
                    end
                    if (res_if.last !== want.last) begin
                        $error("last mismatch: expected %0d, actual %0d",
                               want.last, res_if.last);
                        error_count++;
                    end
                    if (res_if.error !== want.err) begin
                        $error("error mismatch: expected %0d, actual %0d",
                               want.err, res_if.error);
                        error_count++;
                    end
                end
            end
            res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Watchdog: ends the run when no handshake happens for too long.
    always @(posedge clk) begin
        if (!rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Stimulus sequence.
    initial begin
        logic [LEN_W-1:0] len_pick;
        int               pick;

        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_wdata               = '0;
        cmd_if.valid            = 1'b0;
        cmd_if.mode             = '0;
        cmd_if.index            = '0;
        cmd_if.target           = '0;
        cmd_if.red              = '0;
        cmd_if.green            = '0;
        cmd_if.blue             = '0;
        cmd_if.bright           = '0;
        cmd_if.write_colour     = 1'b0;
        cmd_if.write_brightness = 1'b0;
        cmd_if.send             = 1'b0;
        res_if.ready            = 1'b0;
        error_count             = 0;
        stall_cycles            = 0;
        src_idle_pct            = 27;
        snk_idle_pct            = 62;
        strip_len               = LEN_RESET;
        for (int i = 0; i < STRIP_MAX; i++) begin
            red_mem[i]    = '0;
            green_mem[i]  = '0;
            blue_mem[i]   = '0;
            bright_mem[i] = '0;
            remap_mem[i]  = 5'(i);
            virt_mem[i]   = 1'b0;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests at the reset length.
        queue_request(MODE_SEND, 0, 0, 0, 0, 0, 0, 0, 0, 1);
        queue_request(MODE_SET, 0, 0, 8'hFF, 8'h00, 8'hFF, 8'h00, 1, 1, 0);
        queue_request(MODE_SET, 31, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 1, 1);
        queue_request(MODE_SET, 32, 0, 8'h11, 8'h22, 8'h33, 8'h44, 1, 1, 1);
        queue_request(MODE_SET, 255, 255, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 1, 1);
        queue_request(MODE_SET, 5, 0, 8'h12, 8'h34, 8'h56, 8'h78, 0, 0, 1);
        queue_request(MODE_FILL, 0, 0, 8'h55, 8'hAA, 8'h0F, 8'h00, 1, 0, 0);
        queue_request(MODE_FILL, 0, 0, 8'h00, 8'h00, 8'h00, 8'h1F, 0, 1, 1);
        queue_request(MODE_REMAP, 3, 7, 0, 0, 0, 0, 0, 0, 0);
        queue_request(MODE_SET, 3, 0, 8'hAA, 8'hBB, 8'hCC, 8'hDD, 1, 0, 1);
        queue_request(MODE_REMAP, 3, 32, 0, 0, 0, 0, 0, 0, 1);
        queue_request(MODE_REMAP, 255, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_request(MODE_SWAP, 1, 2, 0, 0, 0, 0, 0, 0, 0);
        queue_request(MODE_SET, 1, 0, 8'h01, 8'h02, 8'h03, 8'h04, 1, 1, 0);
        queue_request(MODE_SWAP, 5, 5, 0, 0, 0, 0, 0, 0, 1);
        queue_request(MODE_SWAP, 40, 1, 0, 0, 0, 0, 0, 0, 1);
        queue_request(MODE_VIRT, 4, 0, 0, 0, 0, 0, 0, 0, 1);
        queue_request(MODE_VIRT, 32, 0, 0, 0, 0, 0, 0, 0, 1);
        queue_request(MODE_SPARE_6, 0, 0, 0, 0, 0, 0, 1, 1, 1);
        queue_request(MODE_SPARE_7, 0, 0, 0, 0, 0, 0, 1, 1, 0);
        // Point entry zero beyond the shorter strips used next.
        queue_request(MODE_REMAP, 0, 20, 0, 0, 0, 0, 0, 0, 0);
        wait_strip_idle();

        // A single LED; the write through entry zero lands outside the strip.
        write_strip_length(1);
        queue_request(MODE_SET, 0, 0, 8'h80, 8'h40, 8'h20, 8'h10, 1, 1, 1);
        queue_request(MODE_SET, 1, 0, 8'h80, 8'h40, 8'h20, 8'h10, 1, 1, 1);
        wait_strip_idle();

        // Zero length: every index is out of range and a frame is empty.
        write_strip_length(0);
        queue_request(MODE_SEND, 0, 0, 0, 0, 0, 0, 0, 0, 1);
        queue_request(MODE_SET, 0, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 1, 1);
        wait_strip_idle();

        // A length above the store acts as the full store.
        write_strip_length(63);
        queue_request(MODE_SET, 31, 0, 8'h5A, 8'hA5, 8'h3C, 8'hC3, 1, 1, 1);
        queue_request(MODE_VIRT, 32, 0, 0, 0, 0, 0, 0, 0, 1);
        wait_strip_idle();

        // Random requests in chunks, each with its own strip length.
        for (int c = 0; c < CHUNKS; c++) begin
            if (c == CHUNKS / 3) begin
                src_idle_pct = 62;
                snk_idle_pct = 27;
            end else if (c == 2 * CHUNKS / 3) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            pick = $urandom_range(9);
            if (pick < 3)       len_pick = LEN_W'(32);
            else if (pick == 3) len_pick = LEN_W'(1);
            else if (pick == 4) len_pick = LEN_W'(63);
            else                len_pick = LEN_W'($urandom_range(2, 40));
            write_strip_length(len_pick);
            for (int n = 0; n < CHUNK_ITEMS; n++) queue_random_request();
            wait_strip_idle();
        end

        repeat (END_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/lsfb_pkg.sv
hw/rtl/lsfb_if.sv
hw/rtl/lsfb_front.sv
hw/rtl/lsfb_queue.sv
hw/rtl/lsfb_back.sv
hw/rtl/led_strip_frame_buffer_top.sv
test/tb_led_strip_frame_buffer_top.sv
